### rtl/cot_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package cot_pkg;

   // field widths
   localparam int COORD_W  = 16;
   localparam int SLOT_W   = 6;
   localparam int SIZE_W   = 12;
   localparam int RANGE_W  = 16;
   localparam int KIND_W   = 3;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   // request word layout, lowest bit first
   localparam int REQ_DATA_W  = 112;
   localparam int RSP_DATA_W  = 8;

   localparam int MAX_OBJECTS_DEF = 64;
   localparam int SLOT_SPAN       = 2 ** SLOT_W;

   localparam logic [RANGE_W-1:0] RANGE_LIMIT_RESET = 16'd2400;

   // register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SELF_ACTIVE     = 3'd0,
      CSR_SELF_IS_BOX     = 3'd1,
      CSR_SELF_IS_TRIGGER = 3'd2,
      CSR_SELF_RADIUS     = 3'd3,
      CSR_SELF_HALF_W     = 3'd4,
      CSR_SELF_HALF_H     = 3'd5,
      CSR_RANGE_LIMIT     = 3'd6
   } csr_index_type;

   // event codes
   typedef enum logic [KIND_W-1:0] {
      KIND_COLLIDE_ENTER = 3'd0,
      KIND_COLLIDE_STAY  = 3'd1,
      KIND_COLLIDE_EXIT  = 3'd2,
      KIND_TRIGGER_ENTER = 3'd3,
      KIND_TRIGGER_STAY  = 3'd4,
      KIND_TRIGGER_EXIT  = 3'd5
   } event_kind_type;

endpackage

`default_nettype wire

### rtl/collision_overlap_tracker_top.sv
`timescale 1ns / 1ps
`default_nettype none

// a taken request word's result reaches rsp through the stage 1, 2, 3 and output registers
// throughput: one request word per cycle unless rsp stalls or the clearing pass runs, set
// by the read-modify-write of the overlap bitmap memory (a bypass register covers
// back-to-back words on one slot); reset: synchronous, then the bitmap is cleared one
// entry a cycle over min(MAX_OBJECTS, 64) entries with req_tready low; csr writes as ever
module collision_overlap_tracker_top #(
   parameter int MAX_OBJECTS = cot_pkg::MAX_OBJECTS_DEF
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   // self_x, self_y, other_slot, other_x, other_y, other_has_collider, other_active,
   // other_is_box, other_is_trigger, other_radius, other_half_w, other_half_h, zero pad
   input  wire logic [cot_pkg::REQ_DATA_W-1:0]  req_tdata,
   input  wire logic                            req_tvalid,
   output logic                                 req_tready,
   // event_slot, zero pad
   output logic      [cot_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   // event_kind
   output logic      [cot_pkg::KIND_W-1:0]      rsp_tuser,
   output logic                                 rsp_tvalid,
   input  wire logic                            rsp_tready,
   input  wire logic                            csr_we,
   input  wire logic [cot_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire logic [cot_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   import cot_pkg::*;

   localparam int DEPTH = (MAX_OBJECTS < SLOT_SPAN) ? MAX_OBJECTS : SLOT_SPAN;
   localparam int AW    = $clog2(DEPTH);

   // configuration registers
   logic               self_active_ff;
   logic               self_is_box_ff;
   logic               self_is_trigger_ff;
   logic [SIZE_W-1:0]  self_radius_ff;
   logic [SIZE_W-1:0]  self_half_w_ff;
   logic [SIZE_W-1:0]  self_half_h_ff;
   logic [RANGE_W-1:0] range_limit_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         self_active_ff     <= 1'b1;
         self_is_box_ff     <= 1'b0;
         self_is_trigger_ff <= 1'b0;
         self_radius_ff     <= '0;
         self_half_w_ff     <= '0;
         self_half_h_ff     <= '0;
         range_limit_ff     <= RANGE_LIMIT_RESET;
      end else if (csr_we) begin
         case (csr_index_type'(csr_index))
            CSR_SELF_ACTIVE:     self_active_ff     <= csr_wdata[0];
            CSR_SELF_IS_BOX:     self_is_box_ff     <= csr_wdata[0];
            CSR_SELF_IS_TRIGGER: self_is_trigger_ff <= csr_wdata[0];
            CSR_SELF_RADIUS:     self_radius_ff     <= csr_wdata[SIZE_W-1:0];
            CSR_SELF_HALF_W:     self_half_w_ff     <= csr_wdata[SIZE_W-1:0];
            CSR_SELF_HALF_H:     self_half_h_ff     <= csr_wdata[SIZE_W-1:0];
            CSR_RANGE_LIMIT:     range_limit_ff     <= csr_wdata[RANGE_W-1:0];
            default: ;
         endcase
      end
   end

   // request word fields
   logic signed [COORD_W-1:0] in_self_x, in_self_y, in_other_x, in_other_y;
   logic [SLOT_W-1:0]         in_slot;
   logic                      in_has, in_act, in_box, in_trig;
   logic [SIZE_W-1:0]         in_r, in_hw, in_hh;

   assign in_self_x  = req_tdata[15:0];
   assign in_self_y  = req_tdata[31:16];
   assign in_slot    = req_tdata[37:32];
   assign in_other_x = req_tdata[53:38];
   assign in_other_y = req_tdata[69:54];
   assign in_has     = req_tdata[70];
   assign in_act     = req_tdata[71];
   assign in_box     = req_tdata[72];
   assign in_trig    = req_tdata[73];
   assign in_r       = req_tdata[85:74];
   assign in_hw      = req_tdata[97:86];
   assign in_hh      = req_tdata[109:98];

   // pipeline advance and clearing pass
   logic          adv;
   logic          clear_ff;
   logic [AW-1:0] clr_addr_ff;
   logic          accept;

   assign adv        = !rsp_tvalid || rsp_tready;
   assign req_tready = adv && !clear_ff;
   assign accept     = req_tvalid && req_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         clear_ff    <= 1'b1;
         clr_addr_ff <= '0;
      end else if (clear_ff) begin
         clr_addr_ff <= clr_addr_ff + 1'b1;
         if (clr_addr_ff == AW'(DEPTH - 1)) begin
            clear_ff <= 1'b0;
         end
      end
   end

   // stage 1: center differences and the early skip rules
   logic                      v1_ff;
   logic signed [COORD_W:0]   dx1_ff, dy1_ff;
   logic [SLOT_W-1:0]         slot1_ff;
   logic                      pass1_ff, obox1_ff;
   logic [SIZE_W-1:0]         or1_ff, ohw1_ff, ohh1_ff;
   logic signed [COORD_W:0]   dx1_in, dy1_in;
   logic                      pass1_in;

   assign dx1_in   = {in_self_x[COORD_W-1], in_self_x} - {in_other_x[COORD_W-1], in_other_x};
   assign dy1_in   = {in_self_y[COORD_W-1], in_self_y} - {in_other_y[COORD_W-1], in_other_y};
   assign pass1_in = self_active_ff && in_has && in_act
                     && !(self_is_trigger_ff && in_trig)
                     && (32'(in_slot) < MAX_OBJECTS);

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (adv) begin
         v1_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         dx1_ff   <= dx1_in;
         dy1_ff   <= dy1_in;
         slot1_ff <= in_slot;
         pass1_ff <= pass1_in;
         obox1_ff <= in_box;
         or1_ff   <= in_r;
         ohw1_ff  <= in_hw;
         ohh1_ff  <= in_hh;
      end
   end

   // stage 2: box intervals, clamped offsets and radius sums
   logic signed [COORD_W+1:0] dx1_s, dy1_s, hbx_s, hby_s, hwb_s, hhb_s;
   logic [SIZE_W-1:0]         hw_box, hh_box, r_circ;
   logic [SIZE_W:0]           hx_sum, hy_sum, rs2_in;
   logic signed [COORD_W+1:0] cdx2_in, cdy2_in;
   logic                      boxhit2_in;

   assign hw_box = self_is_box_ff ? self_half_w_ff : ohw1_ff;
   assign hh_box = self_is_box_ff ? self_half_h_ff : ohh1_ff;
   assign r_circ = self_is_box_ff ? or1_ff : self_radius_ff;
   assign hx_sum = {1'b0, self_half_w_ff} + {1'b0, ohw1_ff};
   assign hy_sum = {1'b0, self_half_h_ff} + {1'b0, ohh1_ff};
   assign rs2_in = {1'b0, self_radius_ff} + {1'b0, or1_ff};

   assign dx1_s = {dx1_ff[COORD_W], dx1_ff};
   assign dy1_s = {dy1_ff[COORD_W], dy1_ff};
   assign hbx_s = $signed({5'd0, hx_sum});
   assign hby_s = $signed({5'd0, hy_sum});
   assign hwb_s = $signed({6'd0, hw_box});
   assign hhb_s = $signed({6'd0, hh_box});

   // strict overlap on both axes
   assign boxhit2_in = (dx1_s < hbx_s) && (dx1_s > -hbx_s)
                       && (dy1_s < hby_s) && (dy1_s > -hby_s);

   // offset from the circle center to the nearest box point, per axis
   always_comb begin
      if (dx1_s < -hwb_s) begin
         cdx2_in = dx1_s + hwb_s;
      end else if (dx1_s > hwb_s) begin
         cdx2_in = dx1_s - hwb_s;
      end else begin
         cdx2_in = '0;
      end
      if (dy1_s < -hhb_s) begin
         cdy2_in = dy1_s + hhb_s;
      end else if (dy1_s > hhb_s) begin
         cdy2_in = dy1_s - hhb_s;
      end else begin
         cdy2_in = '0;
      end
   end

   logic                      v2_ff;
   logic signed [COORD_W:0]   dx2_ff, dy2_ff;
   logic signed [COORD_W+1:0] cdx2_ff, cdy2_ff;
   logic [SIZE_W:0]           rs2_ff;
   logic [SIZE_W-1:0]         rc2_ff;
   logic                      boxhit2_ff, pass2_ff, obox2_ff;
   logic [SLOT_W-1:0]         slot2_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else if (adv) begin
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         dx2_ff     <= dx1_ff;
         dy2_ff     <= dy1_ff;
         cdx2_ff    <= cdx2_in;
         cdy2_ff    <= cdy2_in;
         rs2_ff     <= rs2_in;
         rc2_ff     <= r_circ;
         boxhit2_ff <= boxhit2_in;
         pass2_ff   <= pass1_ff;
         obox2_ff   <= obox1_ff;
         slot2_ff   <= slot1_ff;
      end
   end

   // stage 3: squares
   logic signed [2*COORD_W+1:0] dxsq_in, dysq_in;
   logic signed [2*COORD_W+3:0] cdxsq_in, cdysq_in;

   assign dxsq_in  = dx2_ff * dx2_ff;
   assign dysq_in  = dy2_ff * dy2_ff;
   assign cdxsq_in = cdx2_ff * cdx2_ff;
   assign cdysq_in = cdy2_ff * cdy2_ff;

   logic                   v3_ff;
   logic [2*COORD_W-1:0]   dxsq3_ff, dysq3_ff, cdxsq3_ff, cdysq3_ff;
   logic [2*SIZE_W+1:0]    rssq3_ff;
   logic [2*SIZE_W-1:0]    rcsq3_ff;
   logic [2*RANGE_W-1:0]   limsq3_ff;
   logic                   boxhit3_ff, pass3_ff, obox3_ff;
   logic [SLOT_W-1:0]      slot3_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
      end else if (adv) begin
         v3_ff <= v2_ff;
      end
   end

   // every square is below 2^32, so the low 32 bits hold it exactly
   always_ff @(posedge clock) begin
      if (adv) begin
         dxsq3_ff   <= dxsq_in[2*COORD_W-1:0];
         dysq3_ff   <= dysq_in[2*COORD_W-1:0];
         cdxsq3_ff  <= cdxsq_in[2*COORD_W-1:0];
         cdysq3_ff  <= cdysq_in[2*COORD_W-1:0];
         rssq3_ff   <= rs2_ff * rs2_ff;
         rcsq3_ff   <= rc2_ff * rc2_ff;
         limsq3_ff  <= range_limit_ff * range_limit_ff;
         boxhit3_ff <= boxhit2_ff;
         pass3_ff   <= pass2_ff;
         obox3_ff   <= obox2_ff;
         slot3_ff   <= slot2_ff;
      end
   end

   // overlap bitmap: read as the word enters stage 3, written as it leaves
   logic          ram_we;
   logic [AW-1:0] ram_waddr;
   logic [0:0]    ram_wdata;
   logic [0:0]    ram_rdata;

   logic          fwd_valid_ff;
   logic [AW-1:0] fwd_addr_ff;
   logic          fwd_bit_ff;

   logic [2*COORD_W:0] dist_sq, clamp_sq;
   logic               far3, hit3, was3, go3;

   assign dist_sq  = {1'b0, dxsq3_ff} + {1'b0, dysq3_ff};
   assign clamp_sq = {1'b0, cdxsq3_ff} + {1'b0, cdysq3_ff};
   assign far3     = dist_sq > {1'b0, limsq3_ff};
   assign go3      = v3_ff && pass3_ff && !far3;

   // pick the test by the two shapes
   always_comb begin
      if (self_is_box_ff && obox3_ff) begin
         hit3 = boxhit3_ff;
      end else if (!self_is_box_ff && !obox3_ff) begin
         hit3 = dist_sq < (2*COORD_W+1)'(rssq3_ff);
      end else begin
         hit3 = clamp_sq <= (2*COORD_W+1)'(rcsq3_ff);
      end
   end

   // bypass the write that landed on the same edge as this read
   assign was3 = (fwd_valid_ff && fwd_addr_ff == slot3_ff[AW-1:0]) ? fwd_bit_ff
                                                                     : ram_rdata[0];

   assign ram_we    = clear_ff || (adv && go3);
   assign ram_waddr = clear_ff ? clr_addr_ff : slot3_ff[AW-1:0];
   assign ram_wdata = clear_ff ? 1'b0 : hit3;

   always_ff @(posedge clock) begin
      if (reset) begin
         fwd_valid_ff <= 1'b0;
      end else if (adv) begin
         fwd_valid_ff <= go3;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         fwd_addr_ff <= slot3_ff[AW-1:0];
         fwd_bit_ff  <= hit3;
      end
   end

   cot_ram #(
      .WIDTH(1),
      .DEPTH(DEPTH)
   ) u_overlap_map (
      .clock  (clock),
      .wr_en  (ram_we),
      .wr_addr(ram_waddr),
      .wr_data(ram_wdata),
      .rd_en  (adv),
      .rd_addr(slot2_ff[AW-1:0]),
      .rd_data(ram_rdata)
   );

   // event decision
   logic           evt_in;
   event_kind_type kind_in;

   always_comb begin
      evt_in  = 1'b0;
      kind_in = KIND_COLLIDE_ENTER;
      if (go3) begin
         if (was3 && hit3) begin
            evt_in  = 1'b1;
            kind_in = self_is_trigger_ff ? KIND_TRIGGER_STAY : KIND_COLLIDE_STAY;
         end else if (was3) begin
            evt_in  = 1'b1;
            kind_in = self_is_trigger_ff ? KIND_TRIGGER_EXIT : KIND_COLLIDE_EXIT;
         end else if (hit3) begin
            evt_in  = 1'b1;
            kind_in = self_is_trigger_ff ? KIND_TRIGGER_ENTER : KIND_COLLIDE_ENTER;
         end
      end
   end

   // output register
   logic [SLOT_W-1:0] rsp_slot_ff;
   logic [KIND_W-1:0] rsp_kind_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid <= 1'b0;
      end else if (adv) begin
         rsp_tvalid <= evt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv && evt_in) begin
         rsp_slot_ff <= slot3_ff;
         rsp_kind_ff <= kind_in;
      end
   end

   assign rsp_tdata = {(RSP_DATA_W - SLOT_W)'(0), rsp_slot_ff};
   assign rsp_tuser = rsp_kind_ff;

endmodule

`default_nettype wire

### rtl/cot_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module cot_ram #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // single write port, registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

`default_nettype wire
